// ===== hw/rtl/cbd_pkg.sv =====
package cbd_pkg;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] CFG_GAIN_INC   = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_STEP_BASE  = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_LEVEL_LEAK = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_GAIN_LEAK  = 2'd3;

  localparam logic [15:0] GAIN_INC_RST   = 16'd1024;
  localparam logic [15:0] STEP_BASE_RST  = 16'd256;
  localparam logic [14:0] LEVEL_LEAK_RST = 15'd31000;
  localparam logic [15:0] GAIN_LEAK_RST  = 16'd65000;

  typedef struct packed {
    logic [15:0] gain_inc;
    logic [15:0] step_base;
    logic [14:0] level_leak;
    logic [15:0] gain_leak;
  } cfg_t;

endpackage

// ===== hw/rtl/cbd_if.sv =====
interface cbd_in_if #(
  parameter int unsigned BLOCK_BITS = 32
);
  logic                  valid;
  logic                  ready;
  logic [BLOCK_BITS-1:0] block_bits;

  modport source (output valid, output block_bits, input ready);
  modport sink   (input valid, input block_bits, output ready);
endinterface

interface cbd_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample;
  logic               last;

  modport source (output valid, output sample, output last, input ready);
  modport sink   (input valid, input sample, input last, output ready);
endinterface

// ===== hw/rtl/cbd_cfg.sv =====
module cbd_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [cbd_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [cbd_pkg::CfgDataW-1:0]  cfg_data_i,
  output cbd_pkg::cfg_t                 cfg_o
);
  import cbd_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_GAIN_INC:   cfg_d.gain_inc   = cfg_data_i;
        CFG_STEP_BASE:  cfg_d.step_base  = cfg_data_i;
        CFG_LEVEL_LEAK: cfg_d.level_leak = cfg_data_i[14:0];
        CFG_GAIN_LEAK:  cfg_d.gain_leak  = cfg_data_i;
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain_inc   <= GAIN_INC_RST;
      cfg_q.step_base  <= STEP_BASE_RST;
      cfg_q.level_leak <= LEVEL_LEAK_RST;
      cfg_q.gain_leak  <= GAIN_LEAK_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hw/rtl/cvsd_block_decoder_core.sv =====
// CVSD block decoder. Each input beat carries BLOCK_BITS CVSD bits, decoded
// most significant bit first into BLOCK_BITS signed 16-bit PCM samples; the
// final sample of the word carries last. Run counter, gain and previous sample
// persist across words. The word is loaded in the idle state into a shift
// register, and each bit passes through the run, step product, decay product
// and output states in turn; the output state waits while the output stalls.
// These states share one 17x17 multiplier, used in turn for gain*step base,
// previous sample*level leak and gain*gain leak. A new word is accepted
// once the previous one has produced its last sample into the output register.
// Configuration writes must happen only while the decoder is idle.
module cvsd_block_decoder_core #(
  parameter int unsigned BLOCK_BITS = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [cbd_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [cbd_pkg::CfgDataW-1:0]  cfg_data_i,
  cbd_in_if.sink                        bits_in,
  cbd_out_if.source                     pcm_out
);
  import cbd_pkg::*;

  localparam int unsigned CntW = (BLOCK_BITS > 1) ? $clog2(BLOCK_BITS) : 1;
  localparam logic [CntW-1:0] CntLast = CntW'(BLOCK_BITS - 1);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_RUN   = 3'd1;
  localparam logic [2:0] ST_MSTEP = 3'd2;
  localparam logic [2:0] ST_MDEC  = 3'd3;
  localparam logic [2:0] ST_MOUT  = 3'd4;

  localparam logic signed [3:0] RunMax = 4'sd7;
  localparam logic signed [3:0] RunMin = -4'sd7;
  localparam logic signed [3:0] RunHi  = 4'sd3;
  localparam logic signed [3:0] RunLo  = -4'sd3;

  cfg_t cfg;

  cbd_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  logic [2:0]            state_q, state_d;
  logic [BLOCK_BITS-1:0] bits_q, bits_d;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic signed [3:0]     run_q, run_d;
  logic [15:0]           gain_q, gain_d;
  logic signed [15:0]    prev_q, prev_d;
  logic signed [33:0]    prod_q, prod_d;
  logic [24:0]           step_q, step_d;
  logic                  out_valid_q, out_valid_d;
  logic signed [15:0]    out_sample_q, out_sample_d;
  logic                  out_last_q, out_last_d;

  logic signed [16:0]    mul_a, mul_b;
  logic signed [33:0]    mul_p;
  logic                  cur_bit;
  logic signed [3:0]     run_nxt;
  logic [16:0]           gain_sum;
  logic signed [26:0]    decayed;
  logic signed [26:0]    sum_s;
  logic signed [15:0]    sat_s;
  logic                  out_free;

  // shared multiplier, operands chosen by phase
  always_comb begin
    unique case (state_q)
      ST_MSTEP: begin
        mul_a = signed'({1'b0, gain_q});
        mul_b = signed'({1'b0, cfg.step_base});
      end
      ST_MDEC: begin
        mul_a = signed'({prev_q[15], prev_q});
        mul_b = signed'({2'b00, cfg.level_leak});
      end
      default: begin
        mul_a = signed'({1'b0, gain_q});
        mul_b = signed'({1'b0, cfg.gain_leak});
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  assign cur_bit = bits_q[BLOCK_BITS-1];

  always_comb begin
    if (cur_bit) begin
      if (run_q < 4'sd0)        run_nxt = 4'sd1;
      else if (run_q < RunMax)  run_nxt = run_q + 4'sd1;
      else                      run_nxt = run_q;
    end else begin
      if (run_q > 4'sd0)        run_nxt = -4'sd1;
      else if (run_q > RunMin)  run_nxt = run_q - 4'sd1;
      else                      run_nxt = run_q;
    end
  end

  assign gain_sum = {1'b0, gain_q} + {1'b0, cfg.gain_inc};

  // arithmetic shift of the product rounds toward minus infinity
  assign decayed = 27'(signed'(prod_q[33:16]));
  assign sum_s   = cur_bit ? decayed + signed'({2'b00, step_q})
                           : decayed - signed'({2'b00, step_q});

  always_comb begin
    if (sum_s > 27'sd32767)       sat_s = 16'sh7FFF;
    else if (sum_s < -27'sd32768) sat_s = 16'sh8000;
    else                          sat_s = sum_s[15:0];
  end

  assign out_free = !out_valid_q || pcm_out.ready;

  always_comb begin
    state_d      = state_q;
    bits_d       = bits_q;
    cnt_d        = cnt_q;
    run_d        = run_q;
    gain_d       = gain_q;
    prev_d       = prev_q;
    prod_d       = prod_q;
    step_d       = step_q;
    out_valid_d  = out_valid_q && !pcm_out.ready;
    out_sample_d = out_sample_q;
    out_last_d   = out_last_q;

    unique case (state_q)
      ST_IDLE: begin
        if (bits_in.valid) begin
          bits_d  = bits_in.block_bits;
          cnt_d   = '0;
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        run_d = run_nxt;
        if (((run_nxt >= RunHi) || (run_nxt <= RunLo)) && !gain_sum[16]) begin
          gain_d = gain_sum[15:0];
        end
        state_d = ST_MSTEP;
      end
      ST_MSTEP: begin
        prod_d  = mul_p;
        state_d = ST_MDEC;
      end
      ST_MDEC: begin
        step_d  = 25'(cfg.step_base) + 25'(prod_q[31:8]);
        prod_d  = mul_p;
        state_d = ST_MOUT;
      end
      ST_MOUT: begin
        // hold until the output register can take the sample
        if (out_free) begin
          prev_d       = sat_s;
          gain_d       = mul_p[31:16];
          out_valid_d  = 1'b1;
          out_sample_d = sat_s;
          out_last_d   = (cnt_q == CntLast);
          bits_d       = bits_q << 1;
          if (cnt_q == CntLast) begin
            cnt_d   = '0;
            state_d = ST_IDLE;
          end else begin
            cnt_d   = cnt_q + 1'b1;
            state_d = ST_RUN;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      run_q       <= '0;
      gain_q      <= '0;
      prev_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      run_q       <= run_d;
      gain_q      <= gain_d;
      prev_q      <= prev_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bits_q       <= bits_d;
    prod_q       <= prod_d;
    step_q       <= step_d;
    out_sample_q <= out_sample_d;
    out_last_q   <= out_last_d;
  end

  assign bits_in.ready  = (state_q == ST_IDLE);
  assign pcm_out.valid  = out_valid_q;
  assign pcm_out.sample = out_sample_q;
  assign pcm_out.last   = out_last_q;

endmodule
